// ----- hw/rtl/rdc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rdc_pkg
// shared constants, codes and helpers of the reverb delay chain
// ============================================================================
package rdc_pkg;

    localparam int NUM_LINES       = 6;
    localparam int MAX_LINE_LENGTH = 8192;
    localparam int AUDIO_FS_HZ     = 44100;
    localparam int SAMPLE_W        = 16;
    localparam int TABLE_SIZE      = 6;

    localparam int LINE_W      = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int PTR_W       = $clog2(MAX_LINE_LENGTH);
    localparam int LEN_W       = PTR_W + 1;
    localparam int ADDR_W      = LINE_W + PTR_W;
    localparam int STORE_DEPTH = NUM_LINES * MAX_LINE_LENGTH;
    localparam int CNT_W       = $clog2(NUM_LINES + 2);

    localparam int GAIN_W      = 16;
    localparam int COEF_W      = 2 * GAIN_W;
    localparam int UNI_W       = 14;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [GAIN_W-1:0] MIX_GAIN      = 16'd19661;
    localparam logic [GAIN_W-1:0] DECAY_RESET   = 16'd62259;
    localparam logic [UNI_W-1:0]  UNIFORM_RESET = 14'd882;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECAY_GAIN     = 2'd0,
        CFG_USE_UNIFORM    = 2'd1,
        CFG_UNIFORM_LENGTH = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    // per-line loop feedback, Q0.16
    function automatic logic [GAIN_W-1:0] line_feedback(input int line);
        logic [GAIN_W-1:0] fb;
        case (line % TABLE_SIZE)
            0:       fb = 16'd32768;
            1:       fb = 16'd26214;
            2:       fb = 16'd39322;
            3:       fb = 16'd19661;
            4:       fb = 16'd45875;
            default: fb = 16'd13107;
        endcase
        return fb;
    endfunction

    // default line length in samples, capped at the line capacity
    function automatic logic [LEN_W-1:0] default_length(input int line);
        int ms;
        int len;
        case (line % TABLE_SIZE)
            0:       ms = 20;
            1:       ms = 25;
            2:       ms = 30;
            3:       ms = 37;
            4:       ms = 44;
            default: ms = 51;
        endcase
        len = (AUDIO_FS_HZ * ms) / 1000;
        if (len > MAX_LINE_LENGTH)
        begin
            len = MAX_LINE_LENGTH;
        end
        return LEN_W'(len);
    endfunction

    // clamp a two-bit-wider sum to the sample range
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [SAMPLE_W+1:0] v
    );
        logic signed [SAMPLE_W+1:0] hi;
        logic signed [SAMPLE_W+1:0] lo;
        hi = (SAMPLE_W+2)'((1 << (SAMPLE_W - 1)) - 1);
        lo = -hi - (SAMPLE_W+2)'(1);
        if (v > hi)
        begin
            return hi[SAMPLE_W-1:0];
        end
        if (v < lo)
        begin
            return lo[SAMPLE_W-1:0];
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/rdc_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rdc_if
// valid/ready channels of the reverb delay chain: dry samples, wet samples
// and configuration writes
// ============================================================================
interface rdc_in_if
    import rdc_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface rdc_out_if
    import rdc_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface rdc_cfg_if
    import rdc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- hw/rtl/reverb_delay_chain_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// reverb_delay_chain_top
// six feedback comb delay lines in series over one shared delay store
// ============================================================================
// sequencing: a dry item is accepted while idle, then the six lines are walked
//   one per cycle through stage a while the two read / multiply stages b and c drain;
//   the wet item is registered once the output register is free, and no new
//   dry item is taken until the block is back in idle
// reset: asynchronous, active low; the store is not swept, per-line fill
//   flags make never-written entries read as zero, ready straight out of reset
// ============================================================================
module reverb_delay_chain_top
    import rdc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    rdc_cfg_if.sink   cfg,
    rdc_in_if.sink    dry,
    rdc_out_if.source wet
);

    localparam int PROD_W     = SAMPLE_W + COEF_W + 1;   // entry x unsigned coef
    localparam int FB_W       = PROD_W - COEF_W;         // feedback term after rounding
    localparam int MIX_PROD_W = SAMPLE_W + GAIN_W;
    localparam int ACC_W      = SAMPLE_W + 2;
    localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(NUM_LINES + 1);
    localparam logic [CNT_W-1:0]  CNT_LINES  = CNT_W'(NUM_LINES);
    localparam logic [PROD_W-1:0] FB_HALF    = PROD_W'(1) << (COEF_W - 1);
    localparam logic [MIX_PROD_W-1:0] MIX_HALF = MIX_PROD_W'(1) << (GAIN_W - 1);

    // ------------------------------------------------------------------
    // delay store: one synchronous memory, one write and one read a cycle
    // line i occupies addresses {i, ptr}
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] store_mem [STORE_DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]          rd_addr;
    logic [ADDR_W-1:0]          wr_addr;
    logic signed [SAMPLE_W-1:0] wr_data;

    // configuration registers
    logic [GAIN_W-1:0] decay_reg, decay_next;
    logic              use_reg, use_next;
    logic [UNI_W-1:0]  uni_reg, uni_next;

    // per-line state: length, read/write pointer, and whether the line has
    // wrapped since it was last cleared (entries at or past the pointer are
    // then live; before the first wrap they read as zero through the flag)
    logic [LEN_W-1:0] len_reg    [NUM_LINES];
    logic [LEN_W-1:0] len_next   [NUM_LINES];
    logic [PTR_W-1:0] ptr_reg    [NUM_LINES];
    logic [PTR_W-1:0] ptr_next   [NUM_LINES];
    logic             filled_reg [NUM_LINES];
    logic             filled_next[NUM_LINES];

    // sequencer
    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic signed [SAMPLE_W-1:0] sum_reg, sum_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] out_data_reg, out_data_next;

    // stage a -> b: read issued, coefficient formed
    logic              b_valid_reg, b_valid_next;
    logic [LINE_W-1:0] b_line_reg, b_line_next;
    logic [PTR_W-1:0]  b_ptr_reg, b_ptr_next;
    logic              b_fill_reg, b_fill_next;
    logic [COEF_W-1:0] coef_reg, coef_next;

    // stage b -> c: products formed
    logic                         c_valid_reg, c_valid_next;
    logic [LINE_W-1:0]            c_line_reg, c_line_next;
    logic [PTR_W-1:0]             c_ptr_reg, c_ptr_next;
    logic signed [PROD_W-1:0]     fb_prod_reg, fb_prod_next;
    logic signed [MIX_PROD_W-1:0] mix_prod_reg, mix_prod_next;

    logic [GAIN_W-1:0] fb_tab      [NUM_LINES];
    logic [LEN_W-1:0]  default_tab [NUM_LINES];

    logic                         cfg_acc;
    logic                         len_apply;
    logic                         new_use;
    logic [UNI_W-1:0]             new_uni;
    logic [LEN_W-1:0]             uni_len;
    logic                         a_valid;
    logic [LINE_W-1:0]            a_idx;
    logic signed [SAMPLE_W-1:0]   entry_s;
    logic signed [PROD_W-1:0]     fb_rnd;
    logic signed [FB_W-1:0]       fb_val;
    logic signed [MIX_PROD_W-1:0] mix_rnd;
    logic signed [SAMPLE_W-1:0]   mix_val;
    logic signed [SAMPLE_W-1:0]   sum_step;
    logic [LEN_W-1:0]             ptr_inc;
    logic                         out_free;

    // constant per-line tables, settled at elaboration
    always_comb
    begin
        for (int i = 0; i < NUM_LINES; i++)
        begin
            fb_tab[i]      = line_feedback(i);
            default_tab[i] = default_length(i);
        end
    end

    // ------------------------------------------------------------------
    // configuration port: ready only while idle, so a write never meets
    // an item in flight
    // ------------------------------------------------------------------
    assign cfg.ready = (state_reg == ST_IDLE);
    assign cfg_acc   = cfg.valid && cfg.ready;

    always_comb
    begin
        decay_next = decay_reg;
        use_next   = use_reg;
        uni_next   = uni_reg;
        len_apply  = 1'b0;
        if (cfg_acc)
        begin
            unique case (cfg.index)
                CFG_DECAY_GAIN:
                begin
                    decay_next = cfg.wdata[GAIN_W-1:0];
                end
                CFG_USE_UNIFORM:
                begin
                    use_next  = cfg.wdata[0];
                    len_apply = 1'b1;
                end
                CFG_UNIFORM_LENGTH:
                begin
                    uni_next  = cfg.wdata[UNI_W-1:0];
                    len_apply = 1'b1;
                end
                default:
                begin
                    // unknown index: dropped
                end
            endcase
        end
    end

    assign new_use = use_next;
    assign new_uni = uni_next;
    // uniform length capped at the line capacity
    assign uni_len = (32'(new_uni) > 32'(MAX_LINE_LENGTH)) ?
                     LEN_W'(MAX_LINE_LENGTH) : LEN_W'(new_uni);

    // ------------------------------------------------------------------
    // stage a: issue the read of line cnt at its pointer
    // ------------------------------------------------------------------
    assign a_valid = (state_reg == ST_RUN) && (cnt_reg < CNT_LINES);
    assign a_idx   = a_valid ? cnt_reg[LINE_W-1:0] : '0;
    assign rd_addr = {a_idx, ptr_reg[a_idx]};

    always_comb
    begin
        // a zero-length line is bypassed: it never enters stage b
        b_valid_next = a_valid && (len_reg[a_idx] != '0);
        b_line_next  = a_idx;
        b_ptr_next   = ptr_reg[a_idx];
        b_fill_next  = filled_reg[a_idx];
        coef_next    = COEF_W'({{GAIN_W{1'b0}}, fb_tab[a_idx]} *
                               {{GAIN_W{1'b0}}, decay_reg});
    end

    // ------------------------------------------------------------------
    // stage b: read data arrives; both products in parallel
    // ------------------------------------------------------------------
    assign entry_s = b_fill_reg ? rd_data_reg : '0;

    always_comb
    begin
        c_valid_next  = b_valid_reg;
        c_line_next   = b_line_reg;
        c_ptr_next    = b_ptr_reg;
        fb_prod_next  = PROD_W'(entry_s) * $signed(PROD_W'({1'b0, coef_reg}));
        mix_prod_next = MIX_PROD_W'(entry_s) * $signed(MIX_PROD_W'(MIX_GAIN));
    end

    // ------------------------------------------------------------------
    // stage c: round half up, write back sum + feedback, add the mix term
    // ------------------------------------------------------------------
    assign fb_rnd  = fb_prod_reg + $signed(FB_HALF);
    assign fb_val  = $signed(fb_rnd[PROD_W-1:COEF_W]);
    assign mix_rnd = mix_prod_reg + $signed(MIX_HALF);
    assign mix_val = $signed(mix_rnd[MIX_PROD_W-1:GAIN_W]);

    // write uses the sum before this line's mix term
    assign wr_data  = sat_sample(ACC_W'(sum_reg) + ACC_W'(fb_val));
    assign wr_addr  = {c_line_reg, c_ptr_reg};
    assign sum_step = c_valid_reg ? sat_sample(ACC_W'(sum_reg) + ACC_W'(mix_val))
                                  : sum_reg;
    assign ptr_inc  = LEN_W'(c_ptr_reg) + LEN_W'(1);

    // per-line pointer, fill flag and length; a length change clears the
    // line by dropping its fill flag and rewinding the pointer
    always_comb
    begin
        for (int i = 0; i < NUM_LINES; i++)
        begin
            len_next[i]    = len_reg[i];
            ptr_next[i]    = ptr_reg[i];
            filled_next[i] = filled_reg[i];
            if (c_valid_reg && (c_line_reg == LINE_W'(i)))
            begin
                if (ptr_inc >= len_reg[i])
                begin
                    ptr_next[i]    = '0;
                    filled_next[i] = 1'b1;
                end
                else
                begin
                    ptr_next[i] = ptr_inc[PTR_W-1:0];
                end
            end
            if (len_apply)
            begin
                if ((new_use ? uni_len : default_tab[i]) != len_reg[i])
                begin
                    len_next[i]    = new_use ? uni_len : default_tab[i];
                    ptr_next[i]    = '0;
                    filled_next[i] = 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencer and output register
    // the lines are touched in order, one per cycle; stage a of line k+2
    // and stage c of line k never share an entry, so no forwarding
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || wet.ready;
    assign dry.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !wet.ready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (dry.valid)
                begin
                    sum_next   = dry.sample_in;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                sum_next = sum_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = sum_step;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                // previous item still waiting downstream
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = sum_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign wet.valid      = out_valid_reg;
    assign wet.sample_out = out_data_reg;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            decay_reg     <= DECAY_RESET;
            use_reg       <= 1'b0;
            uni_reg       <= UNIFORM_RESET;
            for (int i = 0; i < NUM_LINES; i++)
            begin
                len_reg[i]    <= default_length(i);
                ptr_reg[i]    <= '0;
                filled_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            decay_reg     <= decay_next;
            use_reg       <= use_next;
            uni_reg       <= uni_next;
            for (int i = 0; i < NUM_LINES; i++)
            begin
                len_reg[i]    <= len_next[i];
                ptr_reg[i]    <= ptr_next[i];
                filled_reg[i] <= filled_next[i];
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
        b_line_reg   <= b_line_next;
        b_ptr_reg    <= b_ptr_next;
        b_fill_reg   <= b_fill_next;
        coef_reg     <= coef_next;
        c_line_reg   <= c_line_next;
        c_ptr_reg    <= c_ptr_next;
        fb_prod_reg  <= fb_prod_next;
        mix_prod_reg <= mix_prod_next;
    end

    // delay store ports
    always_ff @(posedge clk)
    begin
        if (c_valid_reg)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/rdc_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rdc_checker
// port-level checks of the reverb delay chain, bound to the top level
// ============================================================================
module rdc_checker
    import rdc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                dry_valid,
    input logic                dry_ready,
    input logic                wet_valid,
    input logic                wet_ready,
    input logic [SAMPLE_W-1:0] wet_sample_out
);

    // a waiting wet item stays offered
    a_wet_hold: assert property (@(posedge clk) disable iff (!rst_n)
        wet_valid && !wet_ready |=> wet_valid)
        else $error("wet item withdrawn while stalled");

    // and keeps its value
    a_wet_stable: assert property (@(posedge clk) disable iff (!rst_n)
        wet_valid && !wet_ready |=> $stable(wet_sample_out))
        else $error("wet item changed while stalled");

    // one item in flight: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        dry_valid && dry_ready |=> !dry_ready)
        else $error("dry item accepted while another is in flight");

    // a wet item is on offer once the lines have been walked for each accept
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        dry_valid && dry_ready |-> ##9 wet_valid)
        else $error("no wet item after dry item");

endmodule

bind reverb_delay_chain_top rdc_checker u_rdc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .dry_valid      (dry.valid),
    .dry_ready      (dry.ready),
    .wet_valid      (wet.valid),
    .wet_ready      (wet.ready),
    .wet_sample_out (wet.sample_out)
);

// ----- tb/reverb_delay_chain_top_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// reverb_delay_chain_top_tb
// self-checking bench for the reverb delay chain: a scoreboard class runs its
// own model of the six feedback comb lines and holds the expected wet items in
// order; directed items cover the edges, then random phases retune the lines
// between bursts of dry items while both channels idle at random
// ============================================================================
import rdc_pkg::*;

class reverb_scoreboard;

    // own copy of the delay lines, their lengths and write positions
    logic signed [SAMPLE_W-1:0] taps [NUM_LINES][MAX_LINE_LENGTH];
    int unsigned tap_len [NUM_LINES];
    int unsigned tap_pos [NUM_LINES];

    logic [GAIN_W-1:0] decay;
    bit                uniform_on;
    logic [UNI_W-1:0]  uniform_len;

    int unsigned loop_gain [TABLE_SIZE] = '{32768, 26214, 39322, 19661, 45875, 13107};
    int unsigned line_ms   [TABLE_SIZE] = '{20, 25, 30, 37, 44, 51};

    logic signed [SAMPLE_W-1:0] wet_expected [$];
    int fails;

    function new();
        decay       = DECAY_RESET;
        uniform_on  = 1'b0;
        uniform_len = UNIFORM_RESET;
        fails       = 0;
        relength(1'b1);
    endfunction

    function int unsigned default_len(int line);
        int unsigned len;
        len = (AUDIO_FS_HZ * line_ms[line % TABLE_SIZE]) / 1000;
        return (len > MAX_LINE_LENGTH) ? MAX_LINE_LENGTH : len;
    endfunction

    // a line whose length changes, or every line if all_lines is set, is cleared and rewound
    function void relength(bit all_lines);
        int unsigned want;
        for (int i = 0; i < NUM_LINES; i++)
        begin
            if (uniform_on)
            begin
                want = (uniform_len > MAX_LINE_LENGTH) ? MAX_LINE_LENGTH : uniform_len;
            end
            else
            begin
                want = default_len(i);
            end
            if (all_lines || want != tap_len[i])
            begin
                tap_len[i] = want;
                tap_pos[i] = 0;
                for (int j = 0; j < MAX_LINE_LENGTH; j++)
                begin
                    taps[i][j] = '0;
                end
            end
        end
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DECAY_GAIN:
            begin
                decay = data[GAIN_W-1:0];
            end
            CFG_USE_UNIFORM:
            begin
                uniform_on = data[0];
                relength(1'b0);
            end
            CFG_UNIFORM_LENGTH:
            begin
                uniform_len = data[UNI_W-1:0];
                relength(1'b0);
            end
            default:
            begin
            end
        endcase
    endfunction

    // floor((p + 2^(s-1)) / 2^s)
    function longint round_q(longint p, int s);
        return (p + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function logic signed [SAMPLE_W-1:0] sat_q15(longint v);
        if (v > 32767)
        begin
            return 16'sh7FFF;
        end
        if (v < -32768)
        begin
            return 16'sh8000;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    function logic signed [SAMPLE_W-1:0] wet_sample_for(logic signed [SAMPLE_W-1:0] dry);
        longint      acc;
        longint      entry;
        longint      coef;
        int unsigned ptr;
        acc = dry;
        for (int i = 0; i < NUM_LINES; i++)
        begin
            if (tap_len[i] != 0)
            begin
                ptr = (tap_pos[i] >= tap_len[i]) ? 0 : tap_pos[i];
                entry = taps[i][ptr];
                coef = longint'(loop_gain[i % TABLE_SIZE]) * longint'(decay);
                taps[i][ptr] = sat_q15(acc + round_q(entry * coef, 32));
                ptr++;
                tap_pos[i] = (ptr >= tap_len[i]) ? 0 : ptr;
                acc = sat_q15(acc + round_q(entry * longint'(MIX_GAIN), 16));
            end
        end
        return acc[SAMPLE_W-1:0];
    endfunction

    function void note_dry(logic signed [SAMPLE_W-1:0] dry);
        wet_expected = {wet_expected, wet_sample_for(dry)};
    endfunction

    task report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fails++;
    endtask

    task check_wet(logic signed [SAMPLE_W-1:0] got);
        logic signed [SAMPLE_W-1:0] want;
        if (wet_expected.size() == 0)
        begin
            report($sformatf("wet item %0d with none expected", got));
        end
        else
        begin
            want = wet_expected.pop_front();
            if (got !== want)
            begin
                report($sformatf("sample_out %0d, expected %0d", got, want));
            end
        end
    endtask

endclass

module reverb_delay_chain_top_tb;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1490;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic [GAIN_W-1:0]          DECAY_LOW  = 16'd45548;
    localparam logic [GAIN_W-1:0]          DECAY_HIGH = 16'd65208;
    localparam logic [GAIN_W-1:0]          DECAY_ZERO = 16'd0;
    localparam logic [GAIN_W-1:0]          DECAY_FULL = 16'hFFFF;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0]       CFG_UNUSED = 2'd3;

    // how the wet side paces its ready
    typedef enum int {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_SPARSE,
        SINK_BLOCKS
    } sink_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    rdc_in_if  dry();
    rdc_out_if wet();
    rdc_cfg_if cfg();

    reverb_delay_chain_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .dry   (dry),
        .wet   (wet)
    );

    reverb_scoreboard sb;

    // sender burst state, shared by every call of send_dry
    int          burst_left;
    int          gap_max;
    int unsigned sink_cycle  = 0;
    sink_mode_t  sink_mode   = SINK_OPEN;
    int          idle_cycles = 0;

    always #CLK_HALF clk = ~clk;

    // wet side: switch stall pattern periodically so that
    // open stretches alternate with random, sparse and blocky back-pressure
    always @(posedge clk)
    begin
        sink_cycle <= sink_cycle + 1;
        if (sink_cycle % 200 == 0)
        begin
            sink_mode <= sink_mode_t'($urandom_range(0, 3));
        end
        case (sink_mode)
            SINK_OPEN:   wet.ready <= 1'b1;
            SINK_RANDOM: wet.ready <= ($urandom_range(0, 9) < 7);
            SINK_SPARSE: wet.ready <= (sink_cycle[2:0] == 3'd0);
            default:     wet.ready <= sink_cycle[4];
        endcase
    end

    // every accepted wet item goes straight to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && wet.valid && wet.ready)
        begin
            sb.check_wet(wet.sample_out);
        end
    end

    // watchdog on cycles in which no channel moves an item
    always @(posedge clk)
    begin
        if (!rst_n || (dry.valid && dry.ready) || (wet.valid && wet.ready)
            || (cfg.valid && cfg.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // offer one dry item, opening a new burst after a random gap when the
    // current one is used up; valid stays high between items of a burst
    task automatic send_dry(input logic signed [SAMPLE_W-1:0] s);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                dry.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        dry.valid     <= 1'b1;
        dry.sample_in <= s;
        do @(posedge clk); while (!dry.ready);
        sb.note_dry(s);
        burst_left--;
    endtask

    // one register write; the caller lowers valid after the last of a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.wdata <= data;
        do @(posedge clk); while (!cfg.ready);
        sb.apply_write(idx, data);
    endtask

    // stop the dry stream and let every expected wet item come out
    task automatic drain();
        dry.valid <= 1'b0;
        while (sb.wet_expected.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_dry();
        logic signed [SAMPLE_W-1:0] s;
        case ($urandom_range(0, 9))
            0:       s = SAMPLE_MAX;
            1:       s = SAMPLE_MIN;
            2, 3:    s = SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
            default: s = SAMPLE_W'($urandom);
        endcase
        return s;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_decay();
        logic [CFG_DATA_W-1:0] d;
        case ($urandom_range(0, 7))
            0:       d = DECAY_ZERO;
            1:       d = DECAY_FULL;
            2:       d = DECAY_LOW;
            3:       d = DECAY_HIGH;
            4, 5:    d = CFG_DATA_W'($urandom_range(DECAY_LOW, DECAY_HIGH));
            default: d = CFG_DATA_W'($urandom);
        endcase
        return d;
    endfunction

    // mostly short lines so the feedback path wraps many times per phase
    function automatic logic [CFG_DATA_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return CFG_DATA_W'($urandom_range(1, 48));
        end
        else if (r < 62)
        begin
            return CFG_DATA_W'($urandom_range(49, 400));
        end
        else if (r < 70)
        begin
            return '0;
        end
        else if (r < 78)
        begin
            return CFG_DATA_W'(sb.uniform_len);
        end
        else if (r < 88)
        begin
            return CFG_DATA_W'(sb.default_len($urandom_range(0, NUM_LINES - 1)));
        end
        else if (r < 94)
        begin
            return CFG_DATA_W'($urandom);
        end
        return ($urandom_range(0, 1) != 0) ? CFG_DATA_W'(MAX_LINE_LENGTH) : CFG_DATA_W'(88);
    endfunction

    // rewrite the registers in a random rotation, now and then skipping one
    // or poking the unused index
    task automatic retune();
        int                    first;
        int                    dir;
        int                    slot;
        logic [CFG_IDX_W-1:0]  idx;
        first = $urandom_range(0, 2);
        dir   = ($urandom_range(0, 1) != 0) ? 1 : 2;
        for (int k = 0; k < 3; k++)
        begin
            slot = (first + k * dir) % 3;
            idx  = CFG_IDX_W'(slot);
            if ($urandom_range(0, 99) >= 15)
            begin
                case (idx)
                    CFG_DECAY_GAIN:  write_reg(idx, pick_decay());
                    CFG_USE_UNIFORM: write_reg(idx, ($urandom_range(0, 4) != 0)
                                                    ? 16'($urandom | 1) : 16'($urandom & 16'hFFFE));
                    default:         write_reg(idx, pick_length());
                endcase
            end
        end
        if ($urandom_range(0, 9) == 0)
        begin
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        end
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        int total;
        int n;

        rst_n         = 1'b0;
        dry.valid     = 1'b0;
        dry.sample_in = '0;
        cfg.valid     = 1'b0;
        cfg.index     = CFG_DECAY_GAIN;
        cfg.wdata     = '0;
        burst_left    = 0;
        gap_max       = 3;
        sb            = new();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: default lengths, lines empty
        send_dry(SAMPLE_MAX);
        send_dry(SAMPLE_MIN);
        send_dry(16'sd0);
        send_dry(16'sd1);
        send_dry(-16'sd1);
        drain();

        // full decay on one-sample lines: the loops saturate at once
        write_reg(CFG_DECAY_GAIN, DECAY_FULL);
        write_reg(CFG_UNIFORM_LENGTH, 16'd1);
        write_reg(CFG_USE_UNIFORM, 16'd1);
        cfg.valid <= 1'b0;
        repeat (3) send_dry(SAMPLE_MAX);
        repeat (3) send_dry(SAMPLE_MIN);
        drain();

        // no decay: loops forget, mix path still sees the stored entry
        write_reg(CFG_DECAY_GAIN, DECAY_ZERO);
        cfg.valid <= 1'b0;
        send_dry(16'sd12345);
        send_dry(-16'sd20000);
        drain();

        // zero length bypasses every line, dry goes straight through
        write_reg(CFG_UNIFORM_LENGTH, 16'd0);
        cfg.valid <= 1'b0;
        send_dry(SAMPLE_MIN);
        send_dry(SAMPLE_MAX);
        drain();

        // unused index is ignored; an oversize length is capped at the line size
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(CFG_DECAY_GAIN, DECAY_HIGH);
        write_reg(CFG_UNIFORM_LENGTH, 16'h3FFF);
        cfg.valid <= 1'b0;
        send_dry(16'sd1000);
        send_dry(-16'sd1000);
        drain();

        // rewriting the same length keeps the lines and their positions
        write_reg(CFG_UNIFORM_LENGTH, 16'd4);
        cfg.valid <= 1'b0;
        repeat (5) send_dry(pick_dry());
        drain();
        write_reg(CFG_UNIFORM_LENGTH, 16'd4);
        write_reg(CFG_DECAY_GAIN, DECAY_LOW);
        cfg.valid <= 1'b0;
        repeat (3) send_dry(pick_dry());
        drain();

        // random phases, each with its own settings and sender pace
        total = 0;
        while (total < RANDOM_ITEMS)
        begin
            retune();
            case ($urandom_range(0, 3))
                0:       gap_max = 0;
                1:       gap_max = 3;
                2:       gap_max = 12;
                default: gap_max = 1;
            endcase
            n = $urandom_range(30, 110);
            repeat (n) send_dry(pick_dry());
            total += n;
            drain();
        end

        if (sb.wet_expected.size() != 0)
        begin
            sb.report($sformatf("%0d wet items never arrived", sb.wet_expected.size()));
        end

        if (sb.fails == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
